// ===== design/level_window_shortest_path_assert.svh =====
// Assertion macros shared by the checker of the level window shortest path block.
`ifndef LEVEL_WINDOW_SHORTEST_PATH_ASSERT_SVH
`define LEVEL_WINDOW_SHORTEST_PATH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWSP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lwsp check failed");

// The consequent must hold in the cycle after the antecedent.
`define LWSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lwsp check failed");

`endif

// ===== design/lwsp_pkg.sv =====
// Package with the constants, codes and state type of the level window shortest path block.
package lwsp_pkg;

   localparam int MAX_NODES = 128;
   localparam int MAX_EDGES = 16384;
   localparam int NODE_AW   = $clog2(MAX_NODES);
   localparam int EDGE_AW   = $clog2(MAX_EDGES);
   localparam int TOTAL_W   = EDGE_AW + 1;

   localparam int LEVEL_W  = 16;
   localparam int COST_W   = 20;
   localparam int DIST_W   = 32;
   localparam int ID_W     = 7;
   localparam int NODE_W   = LEVEL_W + COST_W;
   localparam int EDGE_W   = 2 * ID_W + COST_W;

   localparam logic [DIST_W-1:0] INF_DIST = '1;

   localparam logic [0:0] CSR_LEVEL_SPAN = 1'b0;
   localparam logic [0:0] CSR_NODE_COUNT = 1'b1;

   typedef enum logic [1:0] {
      MODE_NODE = 2'd0,
      MODE_EDGE = 2'd1,
      MODE_RUN  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TOP_RD,
      S_TOP,
      S_CAND_RD,
      S_CAND,
      S_INIT_RD,
      S_INIT_WR,
      S_EDGE_RD,
      S_EDGE_DAT,
      S_RELAX,
      S_WIN_END,
      S_WIN_RES,
      S_DONE
   } state_type;

endpackage

// ===== design/lwsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module lwsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/level_window_shortest_path.sv =====
// Top level: level window shortest path engine with node, edge and distance memories.
// Load items (node or edge) are accepted in the idle state; busy stays low for them.
// A run keeps busy high while it tries each of the C window starts found among the N nodes
// in use; each window initialises the distance RAMs and then runs up to R Bellman-Ford rounds
// (at most N) over the E stored edges, ending early once a round changes no distance.
// The single result shows in the first cycle with busy low again.
// Synchronous reset clears the control state, level_span to 0, node_count to 1 and the edge total.
module level_window_shortest_path (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [lwsp_pkg::ID_W-1:0]       req_target_node,
   input  logic [lwsp_pkg::ID_W-1:0]       req_source_node,
   input  logic [lwsp_pkg::LEVEL_W-1:0]    req_node_level,
   input  logic [lwsp_pkg::COST_W-1:0]     req_cost,
   output logic                            rsp_valid,
   output logic [lwsp_pkg::DIST_W-1:0]     rsp_min_cost,
   input  logic                            csr_write,
   input  logic [0:0]                      csr_index,
   input  logic [lwsp_pkg::LEVEL_W-1:0]    csr_data
);

   import lwsp_pkg::*;

   state_type            state_ff, state_in;
   logic [LEVEL_W-1:0]   span_ff;
   logic [ID_W-1:0]      count_ff;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [LEVEL_W-1:0]   top_ff, top_in, low_ff, low_in;
   logic [ID_W-1:0]      v_ff, v_in, idx_ff, idx_in, r_ff, r_in;
   logic [TOTAL_W-1:0]   e_ff, e_in;
   logic                 changed_ff, changed_in;
   logic [DIST_W-1:0]    best_ff, best_in;
   logic [ID_W-1:0]      ed_dest_ff, ed_dest_in;
   logic [COST_W-1:0]    ed_weight_ff, ed_weight_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]    rsp_cost_ff, rsp_cost_in;

   logic                 node_we, edge_we, dist_we;
   logic [NODE_AW-1:0]   node_wa, node_ra, dist_wa, dist_ra_a, dist_ra_b;
   logic [NODE_W-1:0]    node_wd, node_rd;
   logic [EDGE_AW-1:0]   edge_wa, edge_ra;
   logic [EDGE_W-1:0]    edge_wd, edge_rd;
   logic [DIST_W-1:0]    dist_wd, dist_rd_a, dist_rd_b;

   logic [ID_W-1:0]      nc;
   logic [LEVEL_W-1:0]   rd_level;
   logic [COST_W-1:0]    rd_price;
   logic                 accept, cand_ok, init_ok, lvl_in_win, relax_ok, upd, last_edge;
   logic                 changed_now, last_round;
   logic [DIST_W:0]      sum;
   logic [DIST_W-1:0]    cand;

   lwsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data(node_rd));

   lwsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
      .rd_addr(edge_ra), .rd_data(edge_rd));

   lwsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_a_ram (
      .clock(clock), .wr_en(dist_we), .wr_addr(dist_wa), .wr_data(dist_wd),
      .rd_addr(dist_ra_a), .rd_data(dist_rd_a));

   lwsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_b_ram (
      .clock(clock), .wr_en(dist_we), .wr_addr(dist_wa), .wr_data(dist_wd),
      .rd_addr(dist_ra_b), .rd_data(dist_rd_b));

   assign accept   = req_start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign nc       = (count_ff == '0) ? ID_W'(1) : count_ff;
   assign rd_level = node_rd[NODE_W-1:COST_W];
   assign rd_price = node_rd[COST_W-1:0];

   assign cand_ok    = (rd_level <= top_ff) &&
                       (({1'b0, rd_level} + {1'b0, span_ff}) >= {1'b0, top_ff});
   assign lvl_in_win = (rd_level >= low_ff) &&
                       ({1'b0, rd_level} <= ({1'b0, low_ff} + {1'b0, span_ff}));
   assign init_ok    = (idx_ff != '0) && (idx_ff <= nc) && lvl_in_win;

   assign relax_ok    = (ed_dest_ff != '0) && (ed_dest_ff <= nc) &&
                        (dist_rd_a != INF_DIST) && lvl_in_win;
   assign sum         = {1'b0, dist_rd_a} + {{(DIST_W - COST_W + 1){1'b0}}, ed_weight_ff};
   assign cand        = sum[DIST_W] ? INF_DIST : sum[DIST_W-1:0];
   assign upd         = relax_ok && (cand < dist_rd_b);
   assign last_edge   = ((e_ff + TOTAL_W'(1)) == total_ff);
   assign changed_now = changed_ff || upd;
   assign last_round  = ({1'b0, r_ff} + 8'd1) == {1'b0, nc};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_mode == MODE_RUN)) begin
               state_in = S_TOP_RD;
            end
         end
         S_TOP_RD:  state_in = S_TOP;
         S_TOP:     state_in = S_CAND_RD;
         S_CAND_RD: state_in = S_CAND;
         S_CAND: begin
            if (cand_ok) begin
               state_in = S_INIT_RD;
            end else if (v_ff == nc) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CAND_RD;
            end
         end
         S_INIT_RD: state_in = S_INIT_WR;
         S_INIT_WR: begin
            if (idx_ff != ID_W'(MAX_NODES - 1)) begin
               state_in = S_INIT_RD;
            end else if (total_ff == '0) begin
               state_in = S_WIN_END;
            end else begin
               state_in = S_EDGE_RD;
            end
         end
         S_EDGE_RD:  state_in = S_EDGE_DAT;
         S_EDGE_DAT: state_in = S_RELAX;
         S_RELAX: begin
            if (last_edge && (!changed_now || last_round)) begin
               state_in = S_WIN_END;
            end else begin
               state_in = S_EDGE_RD;
            end
         end
         S_WIN_END: state_in = S_WIN_RES;
         S_WIN_RES: begin
            if (v_ff == nc) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CAND_RD;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      total_in     = total_ff;
      top_in       = top_ff;
      low_in       = low_ff;
      v_in         = v_ff;
      idx_in       = idx_ff;
      r_in         = r_ff;
      e_in         = e_ff;
      changed_in   = changed_ff;
      best_in      = best_ff;
      ed_dest_in   = ed_dest_ff;
      ed_weight_in = ed_weight_ff;
      rsp_valid_in = 1'b0;
      rsp_cost_in  = rsp_cost_ff;
      node_we      = 1'b0;
      node_wa      = req_target_node[NODE_AW-1:0];
      node_wd      = {req_node_level, req_cost};
      node_ra      = idx_ff[NODE_AW-1:0];
      edge_we      = 1'b0;
      edge_wa      = total_ff[EDGE_AW-1:0];
      edge_wd      = {req_source_node, req_target_node, req_cost};
      edge_ra      = e_ff[EDGE_AW-1:0];
      dist_we      = 1'b0;
      dist_wa      = idx_ff[NODE_AW-1:0];
      dist_wd      = init_ok ? {{(DIST_W - COST_W){1'b0}}, rd_price} : INF_DIST;
      dist_ra_a    = edge_rd[EDGE_W-1:EDGE_W-ID_W];
      dist_ra_b    = edge_rd[EDGE_W-ID_W-1:COST_W];
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_mode == MODE_NODE)) begin
               node_we = 1'b1;
            end
            if (accept && (req_mode == MODE_EDGE) && (total_ff < TOTAL_W'(MAX_EDGES))) begin
               edge_we  = 1'b1;
               total_in = total_ff + TOTAL_W'(1);
            end
         end
         S_TOP_RD: node_ra = NODE_AW'(1);
         S_TOP: begin
            top_in  = rd_level;
            best_in = INF_DIST;
            v_in    = ID_W'(1);
         end
         S_CAND_RD: node_ra = v_ff[NODE_AW-1:0];
         S_CAND: begin
            low_in = rd_level;
            idx_in = '0;
            if (!cand_ok) begin
               v_in = v_ff + ID_W'(1);
            end
         end
         S_INIT_RD: node_ra = idx_ff[NODE_AW-1:0];
         S_INIT_WR: begin
            dist_we    = 1'b1;
            idx_in     = idx_ff + ID_W'(1);
            r_in       = '0;
            e_in       = '0;
            changed_in = 1'b0;
         end
         S_EDGE_RD: edge_ra = e_ff[EDGE_AW-1:0];
         S_EDGE_DAT: begin
            node_ra      = edge_rd[EDGE_W-ID_W-1:COST_W];
            ed_dest_in   = edge_rd[EDGE_W-ID_W-1:COST_W];
            ed_weight_in = edge_rd[COST_W-1:0];
         end
         S_RELAX: begin
            dist_we = upd;
            dist_wa = ed_dest_ff[NODE_AW-1:0];
            dist_wd = cand;
            if (last_edge) begin
               e_in       = '0;
               r_in       = r_ff + ID_W'(1);
               changed_in = 1'b0;
            end else begin
               e_in       = e_ff + TOTAL_W'(1);
               changed_in = changed_now;
            end
         end
         S_WIN_END: dist_ra_a = NODE_AW'(1);
         S_WIN_RES: begin
            if (dist_rd_a < best_ff) begin
               best_in = dist_rd_a;
            end
            v_in = v_ff + ID_W'(1);
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_cost_in  = best_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         span_ff      <= '0;
         count_ff     <= ID_W'(1);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_index == CSR_LEVEL_SPAN)) begin
            span_ff <= csr_data;
         end
         if (csr_write && (csr_index == CSR_NODE_COUNT)) begin
            count_ff <= csr_data[ID_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      low_ff       <= low_in;
      v_ff         <= v_in;
      idx_ff       <= idx_in;
      r_ff         <= r_in;
      e_ff         <= e_in;
      changed_ff   <= changed_in;
      best_ff      <= best_in;
      ed_dest_ff   <= ed_dest_in;
      ed_weight_ff <= ed_weight_in;
      rsp_cost_ff  <= rsp_cost_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_min_cost = rsp_cost_ff;

endmodule

// ===== design/lwsp_checker.sv =====
// Port-level checker for the level window shortest path block, bound to the top level.
`include "level_window_shortest_path_assert.svh"

module lwsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_start,
   input logic [1:0] req_mode,
   input logic       busy,
   input logic       rsp_valid
);

   import lwsp_pkg::*;

   `LWSP_ASSERT_NEXT(a_pulse_single, rsp_valid, !rsp_valid)
   `LWSP_ASSERT_NEXT(a_run_goes_busy, req_start && !busy && (req_mode == MODE_RUN), busy)
   `LWSP_ASSERT_NEXT(a_load_stays_free, req_start && !busy && (req_mode != MODE_RUN), !busy)
   `LWSP_ASSERT_NOW(a_result_after_run, $fell(busy), rsp_valid)
   `LWSP_ASSERT_NOW(a_result_when_free, rsp_valid, !busy)

endmodule

bind level_window_shortest_path lwsp_checker u_lwsp_checker (
   .clock(clock),
   .reset(reset),
   .req_start(req_start),
   .req_mode(req_mode),
   .busy(busy),
   .rsp_valid(rsp_valid)
);
